>>> sv/dcdma_pkg.sv
// types and constants for the dual-channel dma with interrupt register
// no dependencies
package dcdma_pkg;

  // request codes
  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_DREQ  = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_IRQ   = 3'd4;

  // register indexes inside a channel
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_ADDR_LO = 3'd1;
  localparam logic [2:0] REG_ADDR_HI = 3'd2;
  localparam logic [2:0] REG_CNT_LO  = 3'd3;
  localparam logic [2:0] REG_CNT_HI  = 3'd4;

  // interrupt register addresses
  localparam logic [4:0] ADDR_INT_MASK = 5'd16;
  localparam logic [4:0] ADDR_INT_PEND = 5'd17;

  // interrupt sources
  localparam logic [2:0] SRC_PERIPH = 3'd3;
  localparam logic [2:0] SRC_TIMER  = 3'd5;

  // control bits
  localparam logic [7:0] CTL_EN    = 8'h01;
  localparam logic [7:0] CTL_DREQ  = 8'h02;
  localparam logic [7:0] CTL_DIR   = 8'h04;
  localparam logic [7:0] CTL_CHAIN = 8'h08;
  localparam logic [7:0] MASK_BITS = 8'h3e;
  localparam logic [7:0] CNT_HIGH_IN = 8'h07;

  // dma done interrupt bits
  localparam logic [7:0] INT_DMA0 = 8'h02;
  localparam logic [7:0] INT_DMA1 = 8'h04;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  read_data;
    logic        xfer_channel;
    logic        xfer_to_ram;
    logic [15:0] xfer_ram_address;
    logic [3:0]  xfer_io_register;
    logic        irq_out;
    logic        final_result;
  } res_t;

endpackage

>>> sv/dual_channel_dma_with_irq_register_top.sv
// top level of the dual-channel dma with interrupt pending/mask register
// depends on dcdma_pkg
// One request item is taken per clock while in_ready is high: register read/write, dreq
// change, dma tick or interrupt source change. All of its work is done combinationally on
// the registered channel state, and its one or two result items go into a four-entry result
// queue that the output side drains at one item per cycle while out_ready is high. An input
// item is accepted while at least two queue entries are free, so requests that give one
// result each flow at one per cycle; a tick on which both channels transfer gives two results,
// and the output rate of one result per cycle is then the limit. No clearing pass after reset.
module dual_channel_dma_with_irq_register_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [4:0]  reg_addr,
  input  logic [7:0]  wdata,
  input  logic        line_channel,
  input  logic        line_level,
  input  logic [2:0]  irq_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  read_data,
  output logic        xfer_channel,
  output logic        xfer_to_ram,
  output logic [15:0] xfer_ram_address,
  output logic [3:0]  xfer_io_register,
  output logic        irq_out,
  output logic        final_result
);

  // channel state
  logic [7:0]  ctl [2];
  logic [15:0] addr [2];
  logic [10:0] cnt [2];
  logic [1:0]  req;
  logic [7:0]  int_pending;
  logic [7:0]  int_enable;

  logic [7:0]  ctl_next [2];
  logic [15:0] addr_next [2];
  logic [10:0] cnt_next [2];
  logic [1:0]  req_next;
  logic [7:0]  int_pending_next;
  logic [7:0]  int_enable_next;

  logic        fire0, fire1;
  logic [7:0]  rd;
  logic        chan;
  logic        two_res;
  dcdma_pkg::res_t res0, res1;

  // result queue
  dcdma_pkg::res_t queue [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic       push, pop;

  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign chan     = reg_addr[3];

  always_comb begin
    ctl_next         = ctl;
    addr_next        = addr;
    cnt_next         = cnt;
    req_next         = req;
    int_pending_next = int_pending;
    int_enable_next  = int_enable;
    rd               = 8'd0;
    fire0            = 1'b0;
    fire1            = 1'b0;
    case (req_type)
      dcdma_pkg::REQ_READ: begin
        if (!reg_addr[4]) begin
          case (reg_addr[2:0])
            dcdma_pkg::REG_CTRL:    rd = ctl[chan];
            dcdma_pkg::REG_ADDR_LO: rd = addr[chan][7:0];
            dcdma_pkg::REG_ADDR_HI: rd = addr[chan][15:8];
            dcdma_pkg::REG_CNT_LO:  rd = cnt[chan][7:0];
            dcdma_pkg::REG_CNT_HI:  rd = {5'd0, cnt[chan][10:8]};
            default:                rd = 8'd0;
          endcase
        end else if (reg_addr == dcdma_pkg::ADDR_INT_MASK) begin
          rd = int_enable;
        end else if (reg_addr == dcdma_pkg::ADDR_INT_PEND) begin
          rd = int_pending;
        end
      end
      dcdma_pkg::REQ_WRITE: begin
        if (!reg_addr[4]) begin
          case (reg_addr[2:0])
            dcdma_pkg::REG_CTRL:
              ctl_next[chan] = (wdata & ~dcdma_pkg::CTL_DREQ) | (ctl[chan] & dcdma_pkg::CTL_DREQ);
            dcdma_pkg::REG_ADDR_LO: addr_next[chan][7:0]  = wdata;
            dcdma_pkg::REG_ADDR_HI: addr_next[chan][15:8] = wdata;
            dcdma_pkg::REG_CNT_LO:  cnt_next[chan][7:0]   = wdata;
            dcdma_pkg::REG_CNT_HI:  cnt_next[chan][10:8]  = wdata[2:0];
            default: ;
          endcase
        end else if (reg_addr == dcdma_pkg::ADDR_INT_MASK) begin
          int_enable_next = wdata & dcdma_pkg::MASK_BITS;
        end else if (reg_addr == dcdma_pkg::ADDR_INT_PEND) begin
          int_pending_next = int_pending & ~wdata;
        end
      end
      dcdma_pkg::REQ_DREQ: begin
        req_next[line_channel] = line_level;
        if (line_level) ctl_next[line_channel] = ctl[line_channel] | dcdma_pkg::CTL_DREQ;
        else ctl_next[line_channel] = ctl[line_channel] & ~dcdma_pkg::CTL_DREQ;
      end
      dcdma_pkg::REQ_TICK: begin
        // channel 0 first; its completion may enable channel 1 for this same tick
        fire0 = ctl[0][0] && req[0] && (cnt[0] != 11'd0);
        if (fire0) begin
          addr_next[0] = addr[0] + 16'd1;
          cnt_next[0]  = cnt[0] - 11'd1;
          if (cnt[0] == 11'd1) begin
            ctl_next[0] = ctl_next[0] & ~dcdma_pkg::CTL_EN;
            if ((ctl_next[1] & dcdma_pkg::CTL_CHAIN) != 8'd0)
              ctl_next[1] = ctl_next[1] | dcdma_pkg::CTL_EN;
            int_pending_next = int_pending_next | dcdma_pkg::INT_DMA0;
          end
        end
        fire1 = ctl_next[1][0] && req[1] && (cnt[1] != 11'd0);
        if (fire1) begin
          addr_next[1] = addr[1] + 16'd1;
          cnt_next[1]  = cnt[1] - 11'd1;
          if (cnt[1] == 11'd1) begin
            ctl_next[1] = ctl_next[1] & ~dcdma_pkg::CTL_EN;
            if ((ctl_next[0] & dcdma_pkg::CTL_CHAIN) != 8'd0)
              ctl_next[0] = ctl_next[0] | dcdma_pkg::CTL_EN;
            int_pending_next = int_pending_next | dcdma_pkg::INT_DMA1;
          end
        end
      end
      dcdma_pkg::REQ_IRQ: begin
        if (irq_source >= dcdma_pkg::SRC_PERIPH && irq_source <= dcdma_pkg::SRC_TIMER) begin
          if (line_level) int_pending_next = int_pending | (8'd1 << irq_source);
          else int_pending_next = int_pending & ~(8'd1 << irq_source);
        end
      end
      default: ;
    endcase
  end

  // build the one or two result items of this request
  always_comb begin
    res0 = '0;
    res1 = '0;
    two_res = fire0 && fire1;
    if (fire0) begin
      res0.result_kind      = 1'b1;
      res0.xfer_channel     = 1'b0;
      res0.xfer_to_ram      = ctl[0][2];
      res0.xfer_ram_address = addr[0];
      res0.xfer_io_register = ctl[0][7:4];
    end else if (fire1) begin
      res0.result_kind      = 1'b1;
      res0.xfer_channel     = 1'b1;
      res0.xfer_to_ram      = ctl[1][2];
      res0.xfer_ram_address = addr[1];
      res0.xfer_io_register = ctl[1][7:4];
    end else begin
      res0.read_data = rd;
    end
    res0.irq_out      = (int_pending_next & int_enable_next) != 8'd0;
    res0.final_result = !two_res;
    res1.result_kind      = 1'b1;
    res1.xfer_channel     = 1'b1;
    res1.xfer_to_ram      = ctl[1][2];
    res1.xfer_ram_address = addr[1];
    res1.xfer_io_register = ctl[1][7:4];
    res1.irq_out          = res0.irq_out;
    res1.final_result     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        ctl[i]  <= 8'd0;
        addr[i] <= 16'd0;
        cnt[i]  <= 11'd0;
      end
      req         <= 2'd0;
      int_pending <= 8'd0;
      int_enable  <= 8'd0;
    end else if (push) begin
      ctl         <= ctl_next;
      addr        <= addr_next;
      cnt         <= cnt_next;
      req         <= req_next;
      int_pending <= int_pending_next;
      int_enable  <= int_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[tail] <= res0;
      if (two_res) queue[tail + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (pop) head <= head + 2'd1;
      if (push) tail <= tail + (two_res ? 2'd2 : 2'd1);
      count <= count + (push ? (two_res ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign result_kind      = queue[head].result_kind;
  assign read_data        = queue[head].read_data;
  assign xfer_channel     = queue[head].xfer_channel;
  assign xfer_to_ram      = queue[head].xfer_to_ram;
  assign xfer_ram_address = queue[head].xfer_ram_address;
  assign xfer_io_register = queue[head].xfer_io_register;
  assign irq_out          = queue[head].irq_out;
  assign final_result     = queue[head].final_result;

endmodule

>>> verif/dual_channel_dma_with_irq_register_top_tb.sv
// self-checking testbench for the dual-channel dma with interrupt pending/mask register
// depends on dcdma_pkg and dual_channel_dma_with_irq_register_top; directed then random requests
`timescale 1ns / 1ps

module dual_channel_dma_with_irq_register_top_tb;

  localparam logic [2:0] SRC_HOST = 3'd4;
  localparam logic [2:0] REQ_MAX_CODE = 3'd7;
  localparam logic [4:0] ADDR_MAX = 5'd31;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] reg_addr;
    logic [7:0] wdata;
    logic       line_channel;
    logic       line_level;
    logic [2:0] irq_source;
  } req_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [4:0]  reg_addr = '0;
  logic [7:0]  wdata = '0;
  logic        line_channel = 1'b0;
  logic        line_level = 1'b0;
  logic [2:0]  irq_source = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  read_data;
  logic        xfer_channel;
  logic        xfer_to_ram;
  logic [15:0] xfer_ram_address;
  logic [3:0]  xfer_io_register;
  logic        irq_out;
  logic        final_result;

  always #2 clk = ~clk;

  dual_channel_dma_with_irq_register_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .reg_addr(reg_addr), .wdata(wdata),
    .line_channel(line_channel), .line_level(line_level), .irq_source(irq_source),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .read_data(read_data), .xfer_channel(xfer_channel),
    .xfer_to_ram(xfer_to_ram), .xfer_ram_address(xfer_ram_address),
    .xfer_io_register(xfer_io_register), .irq_out(irq_out), .final_result(final_result)
  );

  req_item_t          request_queue[$];
  dcdma_pkg::res_t    expected_results[$];

  // shadow copy of the channel and interrupt state
  logic [7:0]  ctl_q [2];
  logic [15:0] adr_q [2];
  logic [10:0] cnt_q [2];
  logic        dreq_q [2];
  logic [7:0]  pend_q;
  logic [7:0]  mask_q;

  int n_total = 0;
  int n_acc = 0;
  int n_res = 0;
  int n_xfer = 0;
  int errors = 0;
  logic in_fire = 1'b0;

  initial begin
    for (int i = 0; i < 2; i++) begin
      ctl_q[i] = '0;
      adr_q[i] = '0;
      cnt_q[i] = '0;
      dreq_q[i] = 1'b0;
    end
    pend_q = '0;
    mask_q = '0;
  end

  function automatic void predict_dma_step(req_item_t it);
    dcdma_pkg::res_t r [2];
    int         n;
    logic       chs;
    logic [7:0] rdv;
    logic [7:0] c;
    n = 0;
    rdv = '0;
    chs = it.reg_addr[3];
    case (it.req_type)
      dcdma_pkg::REQ_READ: begin
        if (it.reg_addr < dcdma_pkg::ADDR_INT_MASK) begin
          case (it.reg_addr[2:0])
            dcdma_pkg::REG_CTRL:    rdv = ctl_q[chs];
            dcdma_pkg::REG_ADDR_LO: rdv = adr_q[chs][7:0];
            dcdma_pkg::REG_ADDR_HI: rdv = adr_q[chs][15:8];
            dcdma_pkg::REG_CNT_LO:  rdv = cnt_q[chs][7:0];
            dcdma_pkg::REG_CNT_HI:  rdv = {5'b0, cnt_q[chs][10:8]};
            default:                rdv = '0;
          endcase
        end else if (it.reg_addr == dcdma_pkg::ADDR_INT_MASK) begin
          rdv = mask_q;
        end else if (it.reg_addr == dcdma_pkg::ADDR_INT_PEND) begin
          rdv = pend_q;
        end
      end
      dcdma_pkg::REQ_WRITE: begin
        if (it.reg_addr < dcdma_pkg::ADDR_INT_MASK) begin
          case (it.reg_addr[2:0])
            dcdma_pkg::REG_CTRL:
              ctl_q[chs] = (it.wdata & ~dcdma_pkg::CTL_DREQ) | (ctl_q[chs] & dcdma_pkg::CTL_DREQ);
            dcdma_pkg::REG_ADDR_LO: adr_q[chs][7:0] = it.wdata;
            dcdma_pkg::REG_ADDR_HI: adr_q[chs][15:8] = it.wdata;
            dcdma_pkg::REG_CNT_LO:  cnt_q[chs][7:0] = it.wdata;
            dcdma_pkg::REG_CNT_HI:  cnt_q[chs][10:8] = it.wdata[2:0];
            default: ;
          endcase
        end else if (it.reg_addr == dcdma_pkg::ADDR_INT_MASK) begin
          mask_q = it.wdata & dcdma_pkg::MASK_BITS;
        end else if (it.reg_addr == dcdma_pkg::ADDR_INT_PEND) begin
          pend_q = pend_q & ~it.wdata;
        end
      end
      dcdma_pkg::REQ_DREQ: begin
        dreq_q[it.line_channel] = it.line_level;
        if (it.line_level)
          ctl_q[it.line_channel] = ctl_q[it.line_channel] | dcdma_pkg::CTL_DREQ;
        else
          ctl_q[it.line_channel] = ctl_q[it.line_channel] & ~dcdma_pkg::CTL_DREQ;
      end
      dcdma_pkg::REQ_TICK: begin
        for (int ch = 0; ch < 2; ch++) begin
          c = ctl_q[ch];
          if ((c & dcdma_pkg::CTL_EN) != 0 && dreq_q[ch] && cnt_q[ch] != 0) begin
            r[n] = '0;
            r[n].result_kind = 1'b1;
            r[n].xfer_channel = ch[0];
            r[n].xfer_to_ram = (c & dcdma_pkg::CTL_DIR) != 0;
            r[n].xfer_ram_address = adr_q[ch];
            r[n].xfer_io_register = c[7:4];
            n++;
            adr_q[ch] = adr_q[ch] + 16'd1;
            cnt_q[ch] = cnt_q[ch] - 11'd1;
            if (cnt_q[ch] == 0) begin
              // done: disable, chain into the other channel, raise dma interrupt
              ctl_q[ch] = ctl_q[ch] & ~dcdma_pkg::CTL_EN;
              if ((ctl_q[1 - ch] & dcdma_pkg::CTL_CHAIN) != 0)
                ctl_q[1 - ch] = ctl_q[1 - ch] | dcdma_pkg::CTL_EN;
              pend_q = pend_q | ((ch == 0) ? dcdma_pkg::INT_DMA0 : dcdma_pkg::INT_DMA1);
            end
          end
        end
      end
      dcdma_pkg::REQ_IRQ: begin
        if (it.irq_source >= dcdma_pkg::SRC_PERIPH && it.irq_source <= dcdma_pkg::SRC_TIMER)
        begin
          if (it.line_level) pend_q = pend_q | (8'd1 << it.irq_source);
          else pend_q = pend_q & ~(8'd1 << it.irq_source);
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      r[0] = '0;
      r[0].read_data = rdv;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      r[k].irq_out = (pend_q & mask_q) != 0;
      r[k].final_result = (k == n - 1);
      expected_results.push_back(r[k]);
    end
  endfunction

  // idle and stall rates follow the progress of the run
  function automatic int phase_now();
    if (n_total == 0) return 0;
    return (n_acc * 4) / n_total;
  endfunction

  function automatic int send_idle_pct();
    case (phase_now())
      1: return 56;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (phase_now())
      2: return 56;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  task automatic push_req(logic [2:0] t, logic [4:0] a, logic [7:0] w, logic c, logic l,
                          logic [2:0] s);
    req_item_t it;
    it.req_type = t;
    it.reg_addr = a;
    it.wdata = w;
    it.line_channel = c;
    it.line_level = l;
    it.irq_source = s;
    request_queue.push_back(it);
  endtask

  task automatic reg_write(logic [4:0] a, logic [7:0] w);
    push_req(dcdma_pkg::REQ_WRITE, a, w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             3'($urandom_range(0, 7)));
  endtask

  task automatic reg_read(logic [4:0] a);
    push_req(dcdma_pkg::REQ_READ, a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endtask

  task automatic set_dreq(logic c, logic l);
    push_req(dcdma_pkg::REQ_DREQ, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), c, l,
             3'($urandom_range(0, 7)));
  endtask

  task automatic dma_tick();
    push_req(dcdma_pkg::REQ_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endtask

  task automatic set_irq_line(logic [2:0] s, logic l);
    push_req(dcdma_pkg::REQ_IRQ, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), l, s);
  endtask

  task automatic program_channel(logic ch, logic [7:0] ctl);
    logic [7:0] cnt_lo;
    cnt_lo = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 6));
    reg_write({1'b0, ch, dcdma_pkg::REG_ADDR_LO}, 8'($urandom_range(0, 255)));
    reg_write({1'b0, ch, dcdma_pkg::REG_ADDR_HI},
              ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255)));
    reg_write({1'b0, ch, dcdma_pkg::REG_CNT_LO}, cnt_lo);
    // mostly short counts; now and then the high count bits too
    reg_write({1'b0, ch, dcdma_pkg::REG_CNT_HI}, ($urandom_range(0, 15) == 0) ?
              8'($urandom_range(0, 255)) :
              (8'($urandom_range(0, 255)) & ~dcdma_pkg::CNT_HIGH_IN));
    reg_write({1'b0, ch, dcdma_pkg::REG_CTRL}, ctl);
    set_dreq(ch, $urandom_range(0, 5) != 0);
  endtask

  task automatic run_ticks();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 5) == 0) reg_read(5'($urandom_range(0, 17)));
      else if ($urandom_range(0, 9) == 0)
        set_dreq(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      dma_tick();
    end
  endtask

  // driver: one item pending at a time, held until accepted
  always @(negedge clk) begin : drive_requests
    req_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        nxt = request_queue.pop_front();
        req_type <= nxt.req_type;
        reg_addr <= nxt.reg_addr;
        wdata <= nxt.wdata;
        line_channel <= nxt.line_channel;
        line_level <= nxt.line_level;
        irq_source <= nxt.irq_source;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= $urandom_range(0, 99) >= recv_stall_pct();
  end

  // monitor: predict on accepted requests, then check accepted results
  always @(posedge clk) begin : check_results
    dcdma_pkg::res_t got;
    dcdma_pkg::res_t want;
    in_fire <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      predict_dma_step({req_type, reg_addr, wdata, line_channel, line_level, irq_source});
      n_acc++;
    end
    if (!rst && out_valid && out_ready) begin
      got = {result_kind, read_data, xfer_channel, xfer_to_ram, xfer_ram_address,
             xfer_io_register, irq_out, final_result};
      n_res++;
      if (got.result_kind) n_xfer++;
      if (expected_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result kind=%0d rd=%02h ch=%0d to_ram=%0d addr=%04h %s",
                   got.result_kind, got.read_data, got.xfer_channel, got.xfer_to_ram,
                   got.xfer_ram_address,
                   $sformatf("io=%0h irq=%0d last=%0d", got.xfer_io_register, got.irq_out,
                             got.final_result));
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind || got.read_data !== want.read_data ||
            got.xfer_channel !== want.xfer_channel || got.xfer_to_ram !== want.xfer_to_ram ||
            got.xfer_ram_address !== want.xfer_ram_address ||
            got.xfer_io_register !== want.xfer_io_register ||
            got.irq_out !== want.irq_out || got.final_result !== want.final_result) begin
          if (errors < 10) begin
            $display("mismatch at result %0d", n_res);
            $display("  exp kind=%0d rd=%02h ch=%0d to_ram=%0d addr=%04h io=%0h irq=%0d last=%0d",
                     want.result_kind, want.read_data, want.xfer_channel, want.xfer_to_ram,
                     want.xfer_ram_address, want.xfer_io_register, want.irq_out,
                     want.final_result);
            $display("  got kind=%0d rd=%02h ch=%0d to_ram=%0d addr=%04h io=%0h irq=%0d last=%0d",
                     got.result_kind, got.read_data, got.xfer_channel, got.xfer_to_ram,
                     got.xfer_ram_address, got.xfer_io_register, got.irq_out,
                     got.final_result);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int target;
    int sel;
    logic ch;
    logic [7:0] cv;

    // directed: register extremes, wrap, chaining into a same-tick transfer, irq sources
    reg_read({1'b0, 1'b0, dcdma_pkg::REG_CTRL});
    reg_write({1'b0, 1'b0, dcdma_pkg::REG_CTRL}, 8'hff);   // dreq mirror bit not written
    reg_read({1'b0, 1'b0, dcdma_pkg::REG_CTRL});
    reg_write({1'b0, 1'b0, dcdma_pkg::REG_ADDR_LO}, 8'hff);
    reg_write({1'b0, 1'b0, dcdma_pkg::REG_ADDR_HI}, 8'hff);
    reg_write({1'b0, 1'b0, dcdma_pkg::REG_CNT_LO}, 8'h02);
    reg_write({1'b0, 1'b0, dcdma_pkg::REG_CNT_HI}, 8'hf8);
    reg_write(dcdma_pkg::ADDR_INT_MASK, 8'hff);
    reg_read(dcdma_pkg::ADDR_INT_MASK);
    set_dreq(1'b0, 1'b1);
    reg_write({1'b0, 1'b1, dcdma_pkg::REG_CTRL}, 8'h5c);   // chain set, not enabled
    reg_write({1'b0, 1'b1, dcdma_pkg::REG_CNT_LO}, 8'h01);
    set_dreq(1'b1, 1'b1);
    dma_tick();
    dma_tick();                                      // ch0 finishes, ch1 runs same tick
    dma_tick();                                      // nothing left to move
    reg_read(dcdma_pkg::ADDR_INT_PEND);
    reg_write(dcdma_pkg::ADDR_INT_PEND, 8'h02);
    set_irq_line(dcdma_pkg::SRC_PERIPH, 1'b1);
    set_irq_line(SRC_HOST, 1'b1);
    set_irq_line(dcdma_pkg::SRC_TIMER, 1'b1);
    set_irq_line(SRC_HOST, 1'b0);
    set_irq_line(3'd0, 1'b1);
    set_irq_line(REQ_MAX_CODE, 1'b1);
    reg_write({1'b0, 1'b1, dcdma_pkg::REG_CNT_HI + 3'd1}, 8'hff);
    reg_read({1'b0, 1'b1, dcdma_pkg::REG_CNT_HI + 3'd1});
    reg_write(ADDR_MAX, 8'h00);
    reg_read(ADDR_MAX);
    for (int t = dcdma_pkg::REQ_IRQ + 1; t <= REQ_MAX_CODE; t++)
      push_req(t[2:0], 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    set_dreq(1'b0, 1'b0);

    target = request_queue.size() + 1550;
    while (request_queue.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        ch = 1'($urandom_range(0, 1));
        cv = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) cv = cv | dcdma_pkg::CTL_EN;
        program_channel(ch, cv);
        run_ticks();
      end else if (sel < 70) begin
        cv = 8'($urandom_range(0, 255)) | dcdma_pkg::CTL_CHAIN;
        program_channel(1'b1, cv & ~dcdma_pkg::CTL_EN);
        cv = 8'($urandom_range(0, 255)) | dcdma_pkg::CTL_EN;
        program_channel(1'b0, cv);
        run_ticks();
        run_ticks();
      end else if (sel < 85) begin
        reg_write(dcdma_pkg::ADDR_INT_MASK, 8'($urandom_range(0, 255)));
        set_irq_line(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        reg_read(dcdma_pkg::ADDR_INT_PEND);
        reg_write(dcdma_pkg::ADDR_INT_PEND, 8'($urandom_range(0, 255)));
        reg_read(dcdma_pkg::ADDR_INT_MASK);
      end else begin
        repeat ($urandom_range(1, 4))
          push_req(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
    end
    n_total = request_queue.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_results.size() != 0) errors++;
    $display("ran %0d requests giving %0d results (%0d transfers) through four idle/stall phases",
             n_acc, n_res, n_xfer);
    $display("%0d mismatches", errors);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/dcdma_pkg.sv
sv/dual_channel_dma_with_irq_register_top.sv
verif/dual_channel_dma_with_irq_register_top_tb.sv
